// ===== rtl/core/block_allocator_fit_policies_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef BLOCK_ALLOCATOR_FIT_POLICIES_DEFINES_SVH
`define BLOCK_ALLOCATOR_FIT_POLICIES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bafp_pkg.sv =====
// Shared constants, codes and types of the block allocator.
// No dependencies.
package bafp_pkg;

    localparam int BLOCKS       = 128;
    localparam int FRAME_BLOCKS = 2;
    localparam int ID_WIDTH     = 16;

    localparam int AW        = $clog2(BLOCKS);
    localparam int CW        = $clog2(BLOCKS + 1);
    localparam int FRAMES    = BLOCKS / FRAME_BLOCKS;
    localparam int FRW       = $clog2(FRAMES + 1);
    localparam int FIW       = $clog2(FRAMES);
    localparam int PG_BLOCKS = FRAMES * FRAME_BLOCKS;
    localparam int POL_W     = 3;
    localparam int SIZE_W    = 8;
    localparam int CELL_W    = 7;
    localparam int EVC_W     = 8;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 40;

    localparam logic [POL_W-1:0] POL_FIRST  = 3'd0;
    localparam logic [POL_W-1:0] POL_NEXT   = 3'd1;
    localparam logic [POL_W-1:0] POL_BEST   = 3'd2;
    localparam logic [POL_W-1:0] POL_WORST  = 3'd3;
    localparam logic [POL_W-1:0] POL_PAGING = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_READ     = 4'd2;
    localparam logic [3:0] OP_FIT      = 4'd3;
    localparam logic [3:0] OP_PLACE    = 4'd4;
    localparam logic [3:0] OP_COMPACT  = 4'd5;
    localparam logic [3:0] OP_EV_INIT  = 4'd6;
    localparam logic [3:0] OP_EV_LOAD  = 4'd7;
    localparam logic [3:0] OP_EV_COUNT = 4'd8;
    localparam logic [3:0] OP_EV_NEXT  = 4'd9;
    localparam logic [3:0] OP_EV_FREE  = 4'd10;
    localparam logic [3:0] OP_PG_COUNT = 4'd11;
    localparam logic [3:0] OP_PG_PLACE = 4'd12;
    localparam logic [3:0] OP_FINISH   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] res;
    } bafp_cmd_t;

    typedef struct packed {
        logic last;
        logic in_read;
        logic in_ok;
        logic paging;
        logic rd_zero;
        logic fit_found;
        logic fit_retry;
        logic compacted;
        logic ev_last;
        logic best_zero;
        logic pg_fit;
        logic out_free;
    } bafp_sts_t;

endpackage

// ===== rtl/core/bafp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bafp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bafp_datapath.sv =====
// Datapath of the allocator: owner table, scan trackers, policy register and result register.
// Depends on bafp_pkg and bafp_ram.
module bafp_datapath
    import bafp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  bafp_cmd_t        cmd,
    output bafp_sts_t        sts,
    input  logic [IN_W-1:0]  in_data,
    input  logic             cfg_wr_en,
    input  logic [POL_W-1:0] cfg_wr_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic                in_mode;
    logic [ID_WIDTH-1:0] in_id;
    logic [SIZE_W-1:0]   in_size;
    logic [CELL_W-1:0]   in_cell;
    logic [SIZE_W:0]     in_frames;

    logic [POL_W-1:0]    policy_reg;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [ID_WIDTH-1:0] id_reg;
    logic [CW-1:0]       size_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [FRW-1:0]      frames_reg;
    logic [AW-1:0]       start_reg;
    logic [ID_WIDTH-1:0] owner_reg;
    logic [EVC_W-1:0]    evicted_reg;
    logic                compacted_reg;

    logic [BLOCKS-1:0]   valid_reg, valid_next;
    logic                vrd_reg;
    logic [ID_WIDTH-1:0] ram_q, d;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ID_WIDTH-1:0] ram_wdata;

    logic [CW-1:0]       run_len_reg, free_cnt_reg, bw_len_reg;
    logic [AW-1:0]       run_start_reg, any_start_reg, ge_start_reg, bw_start_reg;
    logic                any_found_reg, ge_found_reg, bw_found_reg;
    logic [CW-1:0]       wptr_reg;

    logic [AW-1:0]       ev_i_reg;
    logic [ID_WIDTH-1:0] cand_reg, best_id_reg;
    logic [CW-1:0]       ev_n_reg, best_n_reg;
    logic                ev_seen_reg;

    logic [FRW-1:0]      avail_reg, taken_reg;
    logic                frame_ok_reg, pg_first_reg;
    logic [FRAMES-1:0]   fmap_reg;

    logic                last, scan_op, is_free, fok, pg_wr, ended, bw_take, cell_ok;
    logic [AW-1:0]       idx, cur_start, end_start, fit_start, pg_b;
    logic [CW-1:0]       len_inc, end_len, cand_s;
    logic [CW:0]         place_end;
    logic                fit_found;
    logic [OUT_W-1:0]    out_word;

    assign in_mode = in_data[0];
    assign in_id   = in_data[16:1];
    assign in_size = in_data[24:17];
    assign in_cell = in_data[31:25];
    assign in_frames = (SIZE_W + 1)'(({1'b0, in_size} + (SIZE_W + 1)'(FRAME_BLOCKS - 1))
                                     / FRAME_BLOCKS);

    bafp_ram #(.WIDTH(ID_WIDTH), .DEPTH(BLOCKS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign d   = vrd_reg ? ram_q : '0;
    assign idx = AW'(cnt_reg - CW'(1));
    assign cell_ok = (32'(cell_reg) < BLOCKS);

    always_comb begin
        case (cmd.op)
            OP_READ, OP_EV_LOAD: last = (cnt_reg == CW'(1));
            OP_FIT, OP_COMPACT, OP_EV_COUNT, OP_EV_FREE, OP_PG_COUNT:
                last = (cnt_reg == CW'(BLOCKS));
            OP_PLACE:    last = (cnt_reg == size_reg - CW'(1));
            OP_PG_PLACE: last = (cnt_reg == CW'(PG_BLOCKS - 1));
            default:     last = 1'b1;
        endcase
        scan_op = cmd.op inside {OP_READ, OP_EV_LOAD, OP_FIT, OP_COMPACT, OP_EV_COUNT,
                                 OP_EV_FREE, OP_PG_COUNT, OP_PLACE, OP_PG_PLACE};
        cnt_next = (scan_op && !last) ? cnt_reg + CW'(1) : '0;
    end

    always_comb begin
        case (cmd.op)
            OP_READ:    ram_raddr = AW'(cell_reg);
            OP_EV_LOAD: ram_raddr = ev_i_reg;
            default:    ram_raddr = cnt_reg[AW-1:0];
        endcase
    end

    // Free-run tracking for the contiguous policies.
    always_comb begin
        is_free   = (d == '0);
        len_inc   = run_len_reg + CW'(1);
        cur_start = (run_len_reg == '0) ? idx : run_start_reg;
        cand_s    = CW'(idx) + CW'(1) - size_reg;
        ended     = 1'b0;
        end_len   = run_len_reg;
        end_start = run_start_reg;
        if (!is_free && run_len_reg != '0) begin
            ended = 1'b1;
        end else if (is_free && idx == AW'(BLOCKS - 1)) begin
            ended     = 1'b1;
            end_len   = len_inc;
            end_start = cur_start;
        end
        bw_take = ended && end_len >= size_reg &&
                  (!bw_found_reg || (policy_reg == POL_BEST && end_len < bw_len_reg) ||
                   (policy_reg == POL_WORST && end_len > bw_len_reg));
    end

    always_comb begin
        case (policy_reg)
            POL_FIRST: begin
                fit_found = any_found_reg;
                fit_start = any_start_reg;
            end
            POL_NEXT: begin
                fit_found = any_found_reg;
                fit_start = ge_found_reg ? ge_start_reg : any_start_reg;
            end
            default: begin
                fit_found = bw_found_reg;
                fit_start = bw_start_reg;
            end
        endcase
        place_end = (CW + 1)'(fit_start) + (CW + 1)'(size_reg);
        ptr_next  = AW'(place_end % BLOCKS);
    end

    assign fok   = frame_ok_reg && is_free;
    assign pg_b  = cnt_reg[AW-1:0];
    assign pg_wr = fmap_reg[FIW'(pg_b / FRAME_BLOCKS)] && (taken_reg < frames_reg);

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[AW-1:0];
        ram_wdata  = id_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(CW'(fit_start) + cnt_reg);
            end
            OP_COMPACT: begin
                if (cnt_reg != '0 && !is_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = wptr_reg[AW-1:0];
                    ram_wdata = d;
                    valid_next[idx] = 1'b0;
                end
            end
            OP_EV_FREE: begin
                if (cnt_reg != '0 && d == best_id_reg) begin
                    valid_next[idx] = 1'b0;
                end
            end
            OP_PG_PLACE: begin
                ram_we = pg_wr;
            end
            default: begin
            end
        endcase
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_comb begin
        out_word      = '0;
        out_word[1:0] = cmd.res;
        case (cmd.res)
            ST_OK: begin
                out_word[8:2]   = 7'(start_reg);
                out_word[32:25] = evicted_reg;
                out_word[33]    = compacted_reg;
            end
            ST_READ: begin
                out_word[24:9] = 16'(owner_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            policy_reg <= POL_FIRST;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            m_tvalid   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                policy_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_PLACE && last) begin
                ptr_reg <= ptr_next;
            end else if (cmd.op == OP_COMPACT && last) begin
                ptr_reg <= '0;
            end
            if (cmd.op == OP_FINISH) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        vrd_reg <= valid_reg[ram_raddr];
        case (cmd.op)
            OP_LOAD: begin
                id_reg        <= in_id;
                size_reg      <= CW'(in_size);
                cell_reg      <= in_cell;
                frames_reg    <= FRW'(in_frames);
                evicted_reg   <= '0;
                compacted_reg <= 1'b0;
            end
            OP_READ: begin
                if (last) begin
                    owner_reg <= cell_ok ? d : '0;
                end
            end
            OP_FIT: begin
                if (cnt_reg == '0) begin
                    run_len_reg   <= '0;
                    free_cnt_reg  <= '0;
                    any_found_reg <= 1'b0;
                    ge_found_reg  <= 1'b0;
                    bw_found_reg  <= 1'b0;
                end else begin
                    if (is_free) begin
                        run_len_reg   <= len_inc;
                        run_start_reg <= cur_start;
                        free_cnt_reg  <= free_cnt_reg + CW'(1);
                        if (len_inc >= size_reg) begin
                            if (!any_found_reg) begin
                                any_found_reg <= 1'b1;
                                any_start_reg <= AW'(cand_s);
                            end
                            if (!ge_found_reg && AW'(cand_s) >= ptr_reg) begin
                                ge_found_reg <= 1'b1;
                                ge_start_reg <= AW'(cand_s);
                            end
                        end
                    end else begin
                        run_len_reg <= '0;
                    end
                    if (bw_take) begin
                        bw_found_reg <= 1'b1;
                        bw_start_reg <= end_start;
                        bw_len_reg   <= end_len;
                    end
                end
            end
            OP_PLACE: begin
                if (last) begin
                    start_reg <= fit_start;
                end
            end
            OP_COMPACT: begin
                if (cnt_reg == '0) begin
                    wptr_reg <= '0;
                end else if (!is_free) begin
                    wptr_reg <= wptr_reg + CW'(1);
                end
                if (last) begin
                    compacted_reg <= 1'b1;
                end
            end
            OP_EV_INIT: begin
                best_n_reg  <= '0;
                best_id_reg <= '0;
                ev_i_reg    <= '0;
            end
            OP_EV_LOAD: begin
                if (last) begin
                    cand_reg    <= d;
                    ev_n_reg    <= '0;
                    ev_seen_reg <= 1'b0;
                end
            end
            OP_EV_COUNT: begin
                if (cnt_reg != '0 && d == cand_reg) begin
                    ev_n_reg <= ev_n_reg + CW'(1);
                    if (idx < ev_i_reg) begin
                        ev_seen_reg <= 1'b1;
                    end
                end
            end
            OP_EV_NEXT: begin
                if (!ev_seen_reg && ev_n_reg > best_n_reg) begin
                    best_n_reg  <= ev_n_reg;
                    best_id_reg <= cand_reg;
                end
                ev_i_reg <= ev_i_reg + AW'(1);
            end
            OP_EV_FREE: begin
                if (last) begin
                    evicted_reg <= evicted_reg + EVC_W'(1);
                end
            end
            OP_PG_COUNT: begin
                if (cnt_reg == '0) begin
                    avail_reg    <= '0;
                    frame_ok_reg <= 1'b1;
                    taken_reg    <= '0;
                    pg_first_reg <= 1'b1;
                end else if (32'(idx) < PG_BLOCKS) begin
                    if (32'(idx % FRAME_BLOCKS) == FRAME_BLOCKS - 1) begin
                        fmap_reg[FIW'(idx / FRAME_BLOCKS)] <= fok;
                        avail_reg    <= avail_reg + FRW'(fok);
                        frame_ok_reg <= 1'b1;
                    end else begin
                        frame_ok_reg <= fok;
                    end
                end
            end
            OP_PG_PLACE: begin
                if (pg_wr) begin
                    if (pg_first_reg) begin
                        start_reg    <= pg_b;
                        pg_first_reg <= 1'b0;
                    end
                    if (32'(pg_b % FRAME_BLOCKS) == FRAME_BLOCKS - 1) begin
                        taken_reg <= taken_reg + FRW'(1);
                    end
                end
            end
            OP_FINISH: begin
                m_tdata <= out_word;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sts.last      = last;
        sts.in_read   = in_mode;
        sts.in_ok     = (in_id != '0) && (in_size != '0) && (32'(in_size) <= BLOCKS) &&
                        (policy_reg <= POL_PAGING) &&
                        (policy_reg != POL_PAGING || 32'(in_frames) <= FRAMES);
        sts.paging    = (policy_reg == POL_PAGING);
        sts.rd_zero   = is_free;
        sts.fit_found = fit_found;
        sts.fit_retry = (free_cnt_reg >= size_reg);
        sts.compacted = compacted_reg;
        sts.ev_last   = (ev_i_reg == AW'(BLOCKS - 1));
        sts.best_zero = (best_n_reg == '0);
        sts.pg_fit    = (avail_reg >= frames_reg);
        sts.out_free  = !m_tvalid || m_tready;
    end

endmodule

// ===== rtl/core/bafp_ctrl.sv =====
// Controller state machine of the allocator: sequences scans, compaction and eviction.
// Depends on bafp_pkg and the assertion macro header.
`include "block_allocator_fit_policies_defines.svh"

module bafp_ctrl
    import bafp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bafp_sts_t sts,
    output bafp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_READ     = 4'd1;
    localparam logic [3:0] S_FIT      = 4'd2;
    localparam logic [3:0] S_FIT_DEC  = 4'd3;
    localparam logic [3:0] S_PLACE    = 4'd4;
    localparam logic [3:0] S_COMPACT  = 4'd5;
    localparam logic [3:0] S_EV_INIT  = 4'd6;
    localparam logic [3:0] S_EV_LOAD  = 4'd7;
    localparam logic [3:0] S_EV_COUNT = 4'd8;
    localparam logic [3:0] S_EV_NEXT  = 4'd9;
    localparam logic [3:0] S_EV_DEC   = 4'd10;
    localparam logic [3:0] S_EV_FREE  = 4'd11;
    localparam logic [3:0] S_PG_COUNT = 4'd12;
    localparam logic [3:0] S_PG_DEC   = 4'd13;
    localparam logic [3:0] S_PG_PLACE = 4'd14;
    localparam logic [3:0] S_FINISH   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.op     = OP_NONE;
        cmd.res    = res_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    if (sts.in_read) begin
                        state_next = S_READ;
                    end else if (!sts.in_ok) begin
                        res_next   = ST_REJECT;
                        state_next = S_FINISH;
                    end else if (sts.paging) begin
                        state_next = S_PG_COUNT;
                    end else begin
                        state_next = S_FIT;
                    end
                end
            end
            S_READ: begin
                cmd.op = OP_READ;
                if (sts.last) begin
                    res_next   = ST_READ;
                    state_next = S_FINISH;
                end
            end
            S_FIT: begin
                cmd.op = OP_FIT;
                if (sts.last) begin
                    state_next = S_FIT_DEC;
                end
            end
            S_FIT_DEC: begin
                if (sts.fit_found) begin
                    state_next = S_PLACE;
                end else if (sts.fit_retry && !sts.compacted) begin
                    state_next = S_COMPACT;
                end else begin
                    state_next = S_EV_INIT;
                end
            end
            S_PLACE: begin
                cmd.op = OP_PLACE;
                if (sts.last) begin
                    res_next   = ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_COMPACT: begin
                cmd.op = OP_COMPACT;
                if (sts.last) begin
                    state_next = S_FIT;
                end
            end
            S_EV_INIT: begin
                cmd.op     = OP_EV_INIT;
                state_next = S_EV_LOAD;
            end
            S_EV_LOAD: begin
                cmd.op = OP_EV_LOAD;
                if (sts.last) begin
                    state_next = sts.rd_zero ? S_EV_NEXT : S_EV_COUNT;
                end
            end
            S_EV_COUNT: begin
                cmd.op = OP_EV_COUNT;
                if (sts.last) begin
                    state_next = S_EV_NEXT;
                end
            end
            S_EV_NEXT: begin
                cmd.op     = OP_EV_NEXT;
                state_next = sts.ev_last ? S_EV_DEC : S_EV_LOAD;
            end
            S_EV_DEC: begin
                if (sts.best_zero) begin
                    res_next   = ST_REJECT;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_EV_FREE;
                end
            end
            S_EV_FREE: begin
                cmd.op = OP_EV_FREE;
                if (sts.last) begin
                    state_next = sts.paging ? S_PG_COUNT : S_FIT;
                end
            end
            S_PG_COUNT: begin
                cmd.op = OP_PG_COUNT;
                if (sts.last) begin
                    state_next = S_PG_DEC;
                end
            end
            S_PG_DEC: begin
                state_next = sts.pg_fit ? S_PG_PLACE : S_EV_INIT;
            end
            S_PG_PLACE: begin
                cmd.op = OP_PG_PLACE;
                if (sts.last) begin
                    res_next   = ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= ST_REJECT;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    `BAFP_ASSERT_NEXT(a_fit_goes_place, state_reg == S_FIT_DEC && sts.fit_found,
        state_reg == S_PLACE, "fit found but no placement followed")
    `BAFP_ASSERT_SAME(a_compact_once, state_reg == S_COMPACT, !sts.compacted,
        "store compacted twice for one request")
    `BAFP_ASSERT_NEXT(a_finish_holds, state_reg == S_FINISH && !sts.out_free,
        state_reg == S_FINISH, "result dropped while output was full")
    `BAFP_ASSERT_NEXT(a_empty_evict_rejects, state_reg == S_EV_DEC && sts.best_zero,
        state_reg == S_FINISH && res_reg == ST_REJECT, "eviction of an empty store")

endmodule

// ===== rtl/core/block_allocator_fit_policies.sv =====
// Top level of the block allocator with selectable fit policy.
// Depends on bafp_pkg, bafp_ctrl, bafp_datapath and bafp_ram.

// Every request is served one at a time by scans over the owner table, a 128-entry
// RAM with one read and one write port, one block per cycle. A read request looks up
// its cell in the table. A contiguous allocation runs a scan, a decision state and a
// placement pass over the blocks placed; a compaction adds a compaction pass and a
// rescan. Paging runs a count pass, a decision state and a placement pass. An
// eviction loads the owner of each table entry, counts that owner's blocks over the
// whole table for every occupied entry, then frees the victim, before the search is
// repeated. The result is then handed to the output register, which lets the next
// request be accepted while the result waits.
module block_allocator_fit_policies
    import bafp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mode, process_id, request_size, cell_index
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, start_block, owner_id, evicted_count, compacted, zero fill
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_wr_en,
    input  logic [POL_W-1:0] cfg_wr_data
);

    bafp_cmd_t cmd;
    bafp_sts_t sts;

    bafp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bafp_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
